FILE: hdl/alru_pkg.sv
// shared types and constants for the adaptive lru/lfu replacement directory
`default_nettype none
package alru_pkg;

  localparam int CACHE_ENTRIES = 64;
  localparam int HIST_ENTRIES  = 8;
  localparam int COUNT_W       = 16;
  localparam int ADDR_W        = 40;
  localparam int POS_W         = $clog2(CACHE_ENTRIES);
  localparam int USED_W        = $clog2(CACHE_ENTRIES + 1);
  localparam int CPAGES_W      = 7;
  localparam int HPAGES_W      = 4;
  localparam int CFG_DATA_W    = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int WEIGHT_W      = 4;
  localparam int REQ_TYPE_W    = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 4'd5;
  localparam logic [WEIGHT_W-1:0] WEIGHT_HALF  = 4'd5;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX   = 4'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_PAGES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_PAGES  = 1'd1;

  localparam logic [CPAGES_W-1:0] CPAGES_RESET = 7'd64;
  localparam logic [HPAGES_W-1:0] HPAGES_RESET = 4'd7;

  localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_BUILD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]     page_address;
    logic [REQ_TYPE_W-1:0] req_type;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic                evicted;
    logic [ADDR_W-1:0]   victim_address;
    logic                victim_dirty;
    logic                victim_by_lfu;
    logic                seen_in_lru_history;
    logic                seen_in_lfu_history;
    logic [WEIGHT_W-1:0] lru_weight;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic [ADDR_W-1:0]  tag;
    logic               dirty;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
  } ghost_ent_t;

endpackage
`default_nettype wire

FILE: hdl/alru_cell.sv
// one directory cell of the rotating recency chain
`default_nettype none
module alru_cell (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  shift,
  input  alru_pkg::entry_t     d,
  output alru_pkg::entry_t     q
);
  import alru_pkg::*;

  // take the neighbor's entry on every shift, reset empties the cell
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/alru_ghost.sv
// bounded fifo ghost history, newest entry first
`default_nettype none
module alru_ghost (
  input  wire                           clk,
  input  wire                           rst,
  input  wire [alru_pkg::HPAGES_W-1:0]  hist_pages,
  input  wire [alru_pkg::ADDR_W-1:0]    look_tag,
  input  wire                           remove_en,
  input  wire                           push_en,
  input  wire [alru_pkg::ADDR_W-1:0]    push_tag,
  output logic                          found
);
  import alru_pkg::*;

  ghost_ent_t             hist [HIST_ENTRIES];
  ghost_ent_t             hist_next [HIST_ENTRIES];
  ghost_ent_t             removed [HIST_ENTRIES];
  logic [HIST_ENTRIES-1:0] match;
  logic [HIST_ENTRIES-1:0] after;
  logic [ADDR_W-1:0]      key;
  logic [HPAGES_W-1:0]    cap;

  assign key   = push_en ? push_tag : look_tag;
  assign cap   = (hist_pages > HPAGES_W'(HIST_ENTRIES)) ? HPAGES_W'(HIST_ENTRIES) : hist_pages;
  assign found = |match;

  // match flags and the span from the first match to the end
  always_comb begin
    for (int i = 0; i < HIST_ENTRIES; i++) begin
      match[i] = hist[i].valid && (hist[i].tag == key);
    end
    after[0] = match[0];
    for (int i = 1; i < HIST_ENTRIES; i++) begin
      after[i] = after[i-1] | match[i];
    end
  end

  // close the gap left by the first match
  always_comb begin
    for (int i = 0; i < HIST_ENTRIES - 1; i++) begin
      removed[i] = after[i] ? hist[i+1] : hist[i];
    end
    removed[HIST_ENTRIES-1] = after[HIST_ENTRIES-1] ? '0 : hist[HIST_ENTRIES-1];
  end

  // push at the front and trim to the configured depth
  always_comb begin
    for (int i = 0; i < HIST_ENTRIES; i++) begin
      hist_next[i] = hist[i];
    end
    if (push_en) begin
      for (int i = 0; i < HIST_ENTRIES; i++) begin
        if (HPAGES_W'(i) >= cap) begin
          hist_next[i] = '0;
        end else if (i == 0) begin
          hist_next[i] = '{valid: 1'b1, tag: push_tag};
        end else begin
          hist_next[i] = removed[i-1];
        end
      end
    end else if (remove_en) begin
      for (int i = 0; i < HIST_ENTRIES; i++) begin
        hist_next[i] = removed[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < HIST_ENTRIES; i++) begin
      if (rst) begin
        hist[i].valid <= 1'b0;
      end else begin
        hist[i] <= hist_next[i];
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/adaptive_lru_lfu_replacement_unit.sv
// adaptive lru/lfu page directory: rotating cell ring, two ghost histories
// a request passes a full scan of the 64-cell ring, a decide state, a full rebuild
// rotation and a result state; a miss when cache_pages is 0 skips the rebuild
// a new request is taken only in idle, once the last result is in the output
// register; in_stall is high in every other state; a stalled result delays the next one
// reset: directory and histories empty, lru weight 5, cache_pages 64, history_pages 7
`default_nettype none
module adaptive_lru_lfu_replacement_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  alru_pkg::req_t                   in_req,
  output logic                             out_valid,
  input  wire                              out_stall,
  output alru_pkg::rsp_t                   out_rsp,
  input  wire                              cfg_we,
  input  wire [alru_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [alru_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import alru_pkg::*;

  localparam logic [POS_W-1:0] POS_LAST = POS_W'(CACHE_ENTRIES - 1);

  state_t               state, state_next;
  logic [CPAGES_W-1:0]  cache_pages;
  logic [HPAGES_W-1:0]  hist_pages;
  logic [WEIGHT_W-1:0]  weight;
  req_t                 req;
  logic [POS_W-1:0]     pos;
  logic [USED_W-1:0]    used;
  logic                 hit_found, lfu_found;
  logic [POS_W-1:0]     hit_pos, lfu_pos, lru_pos;
  entry_t               hit_ent, lfu_ent, lru_ent;
  entry_t               hold;
  logic                 passing, drop;
  logic [POS_W-1:0]     drop_pos;
  logic                 push_lru, push_lfu;
  rsp_t                 rsp;

  entry_t               cell_q [CACHE_ENTRIES];
  entry_t               head, wb;
  logic                 shift;

  // decide-cycle signals
  logic                 wr, full, evict, use_lru, rebuild;
  logic                 seen_a, seen_b, ghost_a, ghost_b;
  logic [CPAGES_W-1:0]  cap;
  logic [WEIGHT_W-1:0]  weight_next;
  entry_t               new_ent, v_ent;
  logic [POS_W-1:0]     v_pos;
  rsp_t                 rsp_next;
  logic                 ghost_remove, out_free;

  assign head     = cell_q[0];
  assign shift    = (state == ST_SCAN) || (state == ST_BUILD);
  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // ring of cells, head writes back at the tail
  for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
    entry_t d;
    if (g == CACHE_ENTRIES - 1) begin : g_tail
      assign d = wb;
    end else begin : g_mid
      assign d = cell_q[g+1];
    end
    alru_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (cell_q[g])
    );
  end

  // ghost histories
  assign ghost_remove = (state == ST_DECIDE) && !hit_found;

  alru_ghost u_lru_hist (
    .clk        (clk),
    .rst        (rst),
    .hist_pages (hist_pages),
    .look_tag   (req.page_address),
    .remove_en  (ghost_remove),
    .push_en    ((state == ST_BUILD) && (pos == '0) && push_lru),
    .push_tag   (rsp.victim_address),
    .found      (ghost_a)
  );

  alru_ghost u_lfu_hist (
    .clk        (clk),
    .rst        (rst),
    .hist_pages (hist_pages),
    .look_tag   (req.page_address),
    .remove_en  (ghost_remove),
    .push_en    ((state == ST_BUILD) && (pos == '0) && push_lfu),
    .push_tag   (rsp.victim_address),
    .found      (ghost_b)
  );

  // writeback stream: rotate on scan, insert front and drop one on rebuild
  always_comb begin
    wb = head;
    if (state == ST_BUILD && !passing) begin
      wb = hold;
    end
  end

  // replacement decision
  always_comb begin
    wr      = (req.req_type == REQ_WRITE);
    cap     = (cache_pages > CPAGES_W'(CACHE_ENTRIES)) ? CPAGES_W'(CACHE_ENTRIES)
                                                        : cache_pages;
    full    = (used >= USED_W'(cap));
    seen_a  = !hit_found && ghost_a;
    seen_b  = !hit_found && ghost_b;
    weight_next = weight;
    if (seen_a && !seen_b && weight != '0) begin
      weight_next = weight - 1'b1;
    end else if (seen_b && !seen_a && weight < WEIGHT_MAX) begin
      weight_next = weight + 1'b1;
    end
    use_lru = (weight_next >= WEIGHT_HALF);
    evict   = !hit_found && (cap != '0) && full;
    rebuild = hit_found || (cap != '0);
    v_ent   = use_lru ? lru_ent : lfu_ent;
    v_pos   = use_lru ? lru_pos : lfu_pos;
    if (hit_found) begin
      new_ent       = hit_ent;
      new_ent.dirty = hit_ent.dirty | wr;
      new_ent.count = (hit_ent.count == COUNT_MAX) ? hit_ent.count
                                                   : hit_ent.count + 1'b1;
    end else begin
      new_ent = '{valid: 1'b1, tag: req.page_address, dirty: wr,
                  count: COUNT_W'(1)};
    end
    rsp_next.hit                 = hit_found;
    rsp_next.evicted             = evict;
    rsp_next.victim_address      = evict ? v_ent.tag : '0;
    rsp_next.victim_dirty        = evict && v_ent.dirty;
    rsp_next.victim_by_lfu       = evict && !use_lru;
    rsp_next.seen_in_lru_history = seen_a;
    rsp_next.seen_in_lfu_history = seen_b;
    rsp_next.lru_weight          = weight_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (pos == POS_LAST) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = rebuild ? ST_BUILD : ST_DONE;
      end
      ST_BUILD: begin
        if (pos == POS_LAST) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cache_pages <= CPAGES_RESET;
      hist_pages  <= HPAGES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CACHE_PAGES: cache_pages <= cfg_data[CPAGES_W-1:0];
        CFG_HIST_PAGES:  hist_pages  <= cfg_data[HPAGES_W-1:0];
        default: ;
      endcase
    end
  end

  // weight and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      weight    <= WEIGHT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_DECIDE) begin
        weight <= weight_next;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_rsp <= rsp;
    end
  end

  // scan accumulators, decision capture and rebuild stream
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        req       <= in_req;
        pos       <= '0;
        used      <= '0;
        hit_found <= 1'b0;
        lfu_found <= 1'b0;
      end
      ST_SCAN: begin
        pos <= pos + 1'b1;
        if (head.valid) begin
          used    <= used + 1'b1;
          lru_pos <= pos;
          lru_ent <= head;
          if (head.tag == req.page_address) begin
            hit_found <= 1'b1;
            hit_pos   <= pos;
            hit_ent   <= head;
          end
          if (!lfu_found || head.count < lfu_ent.count) begin
            lfu_found <= 1'b1;
            lfu_pos   <= pos;
            lfu_ent   <= head;
          end
        end
      end
      ST_DECIDE: begin
        hold     <= new_ent;
        passing  <= 1'b0;
        drop     <= hit_found || evict;
        drop_pos <= hit_found ? hit_pos : v_pos;
        push_lru <= evict && use_lru;
        push_lfu <= evict && !use_lru;
        rsp      <= rsp_next;
      end
      ST_BUILD: begin
        pos <= pos + 1'b1;
        if (!passing) begin
          if (drop && pos == drop_pos) begin
            passing <= 1'b1;
          end else begin
            hold <= head;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/alru_checker.sv
// port-level checks for the replacement directory, bound to the top level
`default_nettype none
module alru_checker (
  input wire             clk,
  input wire             rst,
  input wire             out_valid,
  input wire             out_stall,
  input alru_pkg::rsp_t  out_rsp
);
  import alru_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  // a hit never evicts and never consults the histories
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_rsp.hit |-> !out_rsp.evicted && !out_rsp.seen_in_lru_history
                                 && !out_rsp.seen_in_lfu_history)
    else $error("hit with eviction or history match");

  // no victim fields without an eviction
  a_no_victim: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_rsp.evicted |-> out_rsp.victim_address == '0
                                      && !out_rsp.victim_dirty && !out_rsp.victim_by_lfu)
    else $error("victim fields set without eviction");

  // weight stays within tenths
  a_weight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_rsp.lru_weight <= WEIGHT_MAX)
    else $error("lru weight out of range");

endmodule

bind adaptive_lru_lfu_replacement_unit alru_checker u_alru_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);
`default_nettype wire
